### rtl/core/whb_pkg.sv
// shared types, codes and saturating arithmetic for the weighted histogram binner
// no dependencies
package whb_pkg;

  localparam int unsigned SUM_W = 48;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned WT_W  = 16;
  localparam int unsigned IN_IDX_W = 10;
  localparam int unsigned BINS_REG_W = 11;
  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_LOW_EDGE    = 2'd0;
  localparam logic [1:0] REG_HIGH_EDGE   = 2'd1;
  localparam logic [1:0] REG_BINS_IN_USE = 2'd2;

  localparam logic [31:0]         LOW_EDGE_RST  = 32'd0;
  localparam logic [31:0]         HIGH_EDGE_RST = 32'd16777216;
  localparam logic [BINS_REG_W-1:0] BINS_RST    = 11'd1024;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // 48-bit signed accumulate of a 16-bit signed weight, clamped at the limits
  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [WT_W-1:0] w);
    logic [SUM_W:0] s;
    logic [SUM_W-1:0] r;
    begin
      s = {a[SUM_W-1], a} + {{(SUM_W+1-WT_W){w[WT_W-1]}}, w};
      if (s[SUM_W] != s[SUM_W-1]) begin
        r = s[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        r = s[SUM_W-1:0];
      end
      return r;
    end
  endfunction

endpackage

### rtl/core/whb_div.sv
// restoring divider, one quotient bit per cycle, for the bin index
// depends on nothing but its parameters
module whb_div #(
  parameter int unsigned QW = 10,
  parameter int unsigned PW = 43
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] dividend_i,
  input  logic [31:0]   divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [PW-1:0] rem_q, den_q;
  logic [QW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic          ge;

  assign ge = (rem_q >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      den_q <= PW'(divisor_i) << (QW - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - den_q;
      end
      quo_q <= QW'({quo_q, ge});
      den_q <= den_q >> 1;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/core/whb_bin_ram.sv
// single-port-write, single-port-read bin memory with registered read data
// depends on nothing but its parameters
module whb_bin_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 48
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/weighted_histogram_binner.sv
// weighted histogram binner: add/clear/read transactions, one at a time
// an add in range gets its bin index from the quotient bits of whb_div, then reads,
// modifies and writes back the bin; out of range adds, reads and no-ops skip the
// divider; clear zeroes one bin memory row per cycle; the output register lets a new
// transaction be taken while the previous result still waits
// after reset a sweep zeroes every row of the bin memory with input stalled
module weighted_histogram_binner #(
  parameter int unsigned MAX_BINS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [whb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic signed [31:0] sample_value_i,
  input  logic signed [15:0] sample_weight_i,
  input  logic [9:0]  bin_index_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic signed [47:0] bin_content_o,
  output logic signed [47:0] underflow_sum_o,
  output logic signed [47:0] overflow_sum_o,
  output logic [31:0] entry_count_o
);

  localparam int unsigned IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned NB_W  = $clog2(MAX_BINS + 1);
  localparam int unsigned PW    = NB_W + 32;
  localparam int unsigned SW    = whb_pkg::SUM_W;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_DEC  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_RD   = 7'b0010000,
    S_CLR  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [31:0] low_q, high_q;
  logic [whb_pkg::BINS_REG_W-1:0] bins_q;

  // held transaction
  whb_pkg::cmd_e cmd_q;
  logic [31:0]   val_q;
  logic [15:0]   wt_q;
  logic [9:0]    idx_q;

  // totals and per-item result
  logic [SW-1:0] under_q, under_d, over_q, over_d;
  logic [31:0]   count_q, count_d;
  whb_pkg::status_e res_status_q, res_status_d;
  logic [SW-1:0] res_content_q, res_content_d;
  logic [IDX_W-1:0] sweep_q, sweep_d;
  logic [IDX_W-1:0] bin_q, bin_d;

  // output register
  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [SW-1:0] out_content_q, out_under_q, out_over_q;
  logic [31:0]   out_count_q;

  logic in_accept, out_load, cfg_write;
  logic [NB_W-1:0] nb;
  logic range_ok, below, above, idx_ok;
  logic [32:0] off_w, span_w;
  logic [PW-1:0] product;
  logic [31:0] idx_ext;

  logic div_start, div_done;
  logic [IDX_W-1:0] quotient;

  logic mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wdata, mem_rdata;
  logic sweep_last;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // effective bin count: zero acts as one, beyond the memory acts as its depth
  always_comb begin
    if (bins_q == '0) begin
      nb = NB_W'(1);
    end else if (32'(bins_q) > 32'(MAX_BINS)) begin
      nb = NB_W'(MAX_BINS);
    end else begin
      nb = NB_W'(bins_q);
    end
  end

  assign range_ok = $signed(high_q) > $signed(low_q);
  assign below    = $signed(val_q) < $signed(low_q);
  assign above    = $signed(val_q) >= $signed(high_q);
  assign off_w    = {val_q[31], val_q} - {low_q[31], low_q};
  assign span_w   = {high_q[31], high_q} - {low_q[31], low_q};
  // bins * offset, registered inside the divider on start
  assign product  = PW'(nb) * PW'(off_w[31:0]);
  assign idx_ext  = 32'(idx_q);
  assign idx_ok   = idx_ext < 32'(nb);
  assign sweep_last = (sweep_q == IDX_W'(MAX_BINS - 1));

  assign div_start = (state_q == S_DEC) && (cmd_q == whb_pkg::CMD_ADD) &&
                     range_ok && !below && !above;

  whb_div #(
    .QW (IDX_W),
    .PW (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (span_w[31:0]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  whb_bin_ram #(
    .DEPTH (MAX_BINS),
    .AW    (IDX_W),
    .DW    (SW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer: reset and clear sweeps, decode, divide, read bin, modify and write back, present result
  always_comb begin
    state_d       = state_q;
    under_d       = under_q;
    over_d        = over_q;
    count_d       = count_q;
    res_status_d  = res_status_q;
    res_content_d = res_content_q;
    sweep_d       = sweep_q;
    bin_d         = bin_q;
    mem_we        = 1'b0;
    mem_waddr     = bin_q;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = idx_ext[IDX_W-1:0];

    unique case (state_q) inside
      S_INIT, S_CLR: begin
        // zero one row per cycle
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        sweep_d   = sweep_q + IDX_W'(1);
        if (sweep_last) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        res_status_d  = whb_pkg::ST_DONE;
        res_content_d = '0;
        state_d       = S_DONE;
        case (cmd_q)
          whb_pkg::CMD_ADD: begin
            if (!range_ok) begin
              res_status_d = whb_pkg::ST_INVALID;
            end else if (below) begin
              res_status_d = whb_pkg::ST_UNDER;
              under_d      = whb_pkg::sat_add(under_q, wt_q);
            end else if (above) begin
              res_status_d = whb_pkg::ST_OVER;
              over_d       = whb_pkg::sat_add(over_q, wt_q);
            end else begin
              state_d = S_DIV;
            end
          end
          whb_pkg::CMD_CLEAR: begin
            under_d = '0;
            over_d  = '0;
            count_d = '0;
            sweep_d = '0;
            state_d = S_CLR;
          end
          whb_pkg::CMD_READ: begin
            if (idx_ok) begin
              mem_re  = 1'b1;
              state_d = S_RD;
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          mem_re    = 1'b1;
          mem_raddr = quotient;
          bin_d     = quotient;
          state_d   = S_RD;
        end
      end
      S_RD: begin
        if (cmd_q == whb_pkg::CMD_ADD) begin
          mem_we    = 1'b1;
          mem_wdata = whb_pkg::sat_add(mem_rdata, wt_q);
          if (count_q != whb_pkg::CNT_MAX) begin
            count_d = count_q + 32'd1;
          end
        end else begin
          res_content_d = mem_rdata;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      sweep_q      <= '0;
      under_q      <= '0;
      over_q       <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= whb_pkg::ST_DONE;
      low_q        <= whb_pkg::LOW_EDGE_RST;
      high_q       <= whb_pkg::HIGH_EDGE_RST;
      bins_q       <= whb_pkg::BINS_RST;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      under_q      <= under_d;
      over_q       <= over_d;
      count_q      <= count_d;
      res_status_q <= res_status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_write) begin
        case (paddr[3:2])
          whb_pkg::REG_LOW_EDGE:    low_q  <= pwdata;
          whb_pkg::REG_HIGH_EDGE:   high_q <= pwdata;
          whb_pkg::REG_BINS_IN_USE: bins_q <= pwdata[whb_pkg::BINS_REG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_content_q <= res_content_d;
    bin_q         <= bin_d;
    if (in_accept) begin
      cmd_q <= whb_pkg::cmd_e'(cmd_i);
      val_q <= sample_value_i;
      wt_q  <= sample_weight_i;
      idx_q <= bin_index_i;
    end
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_content_q <= res_content_q;
      out_under_q   <= under_q;
      out_over_q    <= over_q;
      out_count_q   <= count_q;
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      whb_pkg::REG_LOW_EDGE:    prdata = low_q;
      whb_pkg::REG_HIGH_EDGE:   prdata = high_q;
      whb_pkg::REG_BINS_IN_USE: prdata = 32'(bins_q);
      default:                  prdata = '0;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign bin_content_o   = out_content_q;
  assign underflow_sum_o = out_under_q;
  assign overflow_sum_o  = out_over_q;
  assign entry_count_o   = out_count_q;

  // divider result only arrives while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  // bin memory written only by a sweep or a read-modify-write of an add
  a_mem_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_INIT || state_q == S_CLR ||
                (state_q == S_RD && cmd_q == whb_pkg::CMD_ADD)))
    else $error("unexpected bin memory write");

  // a clear transaction, once taken, passes through the decode state and then starts a sweep
  a_clear_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && cmd_i == whb_pkg::CMD_CLEAR) |=> ##1 (state_q == S_CLR))
    else $error("clear did not start a sweep");

endmodule
